[src/dnts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnts_pkg
// Shared constants, types and character classing for the decimal number
// text scanner.
// ----------------------------------------------------------------------------
package dnts_pkg;

  localparam int unsigned MaxSigDigits = 18;
  localparam int unsigned MaxExp       = 9999;
  localparam int unsigned ScaleLimit   = 10000;

  localparam int unsigned MantW  = 60;
  localparam int unsigned ExpW   = 16;
  localparam int unsigned EaccW  = 14;
  localparam int unsigned SigW   = 5;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;

  typedef struct packed {
    logic       blank;
    logic       digit;
    logic       sign;
    logic       minus;
    logic       point;
    logic       expo;
    logic [3:0] value;
  } char_class_t;

  typedef struct packed {
    logic                   negative;
    logic [MantW-1:0]       mantissa;
    logic signed [ExpW-1:0] dec_exponent;
    logic                   no_digits;
    logic                   truncated;
  } scan_result_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cc;
    logic [7:0]  diff;
    diff     = c - ChZero;
    cc.blank = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    cc.digit = (c >= ChZero) && (c <= ChNine);
    cc.sign  = (c == ChPlus) || (c == ChMinus);
    cc.minus = (c == ChMinus);
    cc.point = (c == ChPoint);
    cc.expo  = (c == ChLowE) || (c == ChUpE);
    cc.value = diff[3:0];
    return cc;
  endfunction

endpackage

[src/decimal_number_text_scanner.sv]
`timescale 1ns / 1ps
// a result is on the master side in the cycle after the final character's transfer
// throughput: one character per cycle when ready; one mul-by-ten-and-add per character
// a result not yet taken holds off the slave side; taking it frees the input that cycle
// reset: asynchronous, active low; scanner returns to the white space phase,
// output register empties
// ----------------------------------------------------------------------------
// decimal_number_text_scanner
// Streams characters in and emits sign, mantissa and decimal exponent of the
// scanned number on each character marked last.
// ----------------------------------------------------------------------------
module decimal_number_text_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [0] negative, [60:1] mantissa,
                                        // [76:61] dec_exponent, [79:77] zero
  output logic [1:0]  m_axis_tuser_o    // [0] no_digits, [1] truncated
);

  logic                   in_xfer;
  logic                   out_valid_q;
  dnts_pkg::scan_result_t res, res_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  dnts_scan_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_xfer),
    .ch_i     (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tlast_i) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, res_q.dec_exponent, res_q.mantissa, res_q.negative};
  assign m_axis_tuser_o  = {res_q.truncated, res_q.no_digits};

endmodule

[src/dnts_scan_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnts_scan_core
// Per-character scan state: phase, sign, mantissa accumulator, scale and
// exponent accumulators; forms the result on the final character.
// ----------------------------------------------------------------------------
module dnts_scan_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            ch_i,
  input  logic                  last_i,
  output dnts_pkg::scan_result_t result_o
);

  typedef enum logic [2:0] {
    PhSpace,
    PhInt,
    PhFrac,
    PhExpStart,
    PhExpDigits,
    PhDone
  } phase_e;

  localparam logic [dnts_pkg::SigW-1:0] SigMax = dnts_pkg::SigW'(dnts_pkg::MaxSigDigits);
  localparam logic signed [dnts_pkg::ExpW-1:0] ScaleHi =
    dnts_pkg::ExpW'(dnts_pkg::ScaleLimit);
  localparam logic signed [dnts_pkg::ExpW-1:0] ScaleLo =
    -dnts_pkg::ExpW'(dnts_pkg::ScaleLimit);
  localparam logic signed [dnts_pkg::ExpW-1:0] ScaleOne = dnts_pkg::ExpW'(1);
  localparam logic [16:0] ExpMax17 = 17'(dnts_pkg::MaxExp);

  phase_e                                phase_q, phase_d;
  logic                                  sign_neg_q, sign_neg_d;
  logic [dnts_pkg::MantW-1:0]            mant_q, mant_d;
  logic signed [dnts_pkg::ExpW-1:0]      scale_q, scale_d;
  logic [dnts_pkg::SigW-1:0]             sig_q, sig_d;
  logic                                  exp_neg_q, exp_neg_d;
  logic [dnts_pkg::EaccW-1:0]            eacc_q, eacc_d;
  logic                                  seen_q, seen_d;
  logic                                  lost_q, lost_d;

  dnts_pkg::char_class_t cc;
  logic                  take_mant, in_frac, take_exp, scale_up, scale_dn;
  logic [16:0]           exp_next;
  logic signed [16:0]    exp_signed, e_sum;

  assign cc = dnts_pkg::classify(ch_i);

  always_comb begin
    phase_d    = phase_q;
    sign_neg_d = sign_neg_q;
    mant_d     = mant_q;
    scale_d    = scale_q;
    sig_d      = sig_q;
    exp_neg_d  = exp_neg_q;
    eacc_d     = eacc_q;
    seen_d     = seen_q;
    lost_d     = lost_q;
    take_mant  = 1'b0;
    in_frac    = 1'b0;
    take_exp   = 1'b0;
    scale_up   = 1'b0;
    scale_dn   = 1'b0;
    exp_next   = 17'(eacc_q) * 17'd10 + 17'(cc.value);

    if (en_i) begin
      unique case (phase_q)
        PhSpace: begin
          if (cc.blank) begin
            phase_d = PhSpace;
          end else if (cc.sign) begin
            sign_neg_d = cc.minus;
            phase_d    = PhInt;
          end else if (cc.digit) begin
            take_mant = 1'b1;
            phase_d   = PhInt;
          end else if (cc.point) begin
            phase_d = PhFrac;
          end else begin
            phase_d = PhDone;
          end
        end
        PhInt: begin
          if (cc.digit) begin
            take_mant = 1'b1;
          end else if (cc.point) begin
            phase_d = PhFrac;
          end else if (cc.expo && seen_q) begin
            phase_d = PhExpStart;
          end else begin
            phase_d = PhDone;
          end
        end
        PhFrac: begin
          if (cc.digit) begin
            take_mant = 1'b1;
            in_frac   = 1'b1;
          end else if (cc.expo && seen_q) begin
            phase_d = PhExpStart;
          end else begin
            phase_d = PhDone;
          end
        end
        PhExpStart: begin
          if (cc.sign) begin
            exp_neg_d = cc.minus;
            phase_d   = PhExpDigits;
          end else if (cc.digit) begin
            take_exp = 1'b1;
            phase_d  = PhExpDigits;
          end else begin
            phase_d = PhDone;
          end
        end
        PhExpDigits: begin
          if (cc.digit) begin
            take_exp = 1'b1;
          end else begin
            phase_d = PhDone;
          end
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end

    // mantissa digit
    if (take_mant) begin
      seen_d = 1'b1;
      if ((mant_q == '0) && (cc.value == 4'd0)) begin
        scale_dn = in_frac;
      end else if (sig_q < SigMax) begin
        mant_d   = mant_q * dnts_pkg::MantW'(10) + dnts_pkg::MantW'(cc.value);
        sig_d    = sig_q + 1'b1;
        scale_dn = in_frac;
      end else begin
        lost_d   = 1'b1;
        scale_up = !in_frac;
      end
    end

    // scale moves by one and saturates
    if (scale_up) begin
      if (scale_q == ScaleHi) begin
        lost_d = 1'b1;
      end else begin
        scale_d = scale_q + ScaleOne;
      end
    end else if (scale_dn) begin
      if (scale_q == ScaleLo) begin
        lost_d = 1'b1;
      end else begin
        scale_d = scale_q - ScaleOne;
      end
    end

    // exponent digit
    if (take_exp) begin
      if (exp_next > ExpMax17) begin
        eacc_d = dnts_pkg::EaccW'(dnts_pkg::MaxExp);
        lost_d = 1'b1;
      end else begin
        eacc_d = exp_next[dnts_pkg::EaccW-1:0];
      end
    end

    exp_signed = exp_neg_d ? -$signed(17'(eacc_d)) : $signed(17'(eacc_d));
    e_sum      = 17'(scale_d) + exp_signed;

    result_o.negative = sign_neg_d;
    if (seen_d) begin
      result_o.mantissa     = mant_d;
      result_o.dec_exponent = e_sum[dnts_pkg::ExpW-1:0];
      result_o.no_digits    = 1'b0;
      result_o.truncated    = lost_d;
    end else begin
      result_o.mantissa     = '0;
      result_o.dec_exponent = '0;
      result_o.no_digits    = 1'b1;
      result_o.truncated    = 1'b0;
    end

    // back to the start after the final character
    if (en_i && last_i) begin
      phase_d    = PhSpace;
      sign_neg_d = 1'b0;
      mant_d     = '0;
      scale_d    = '0;
      sig_d      = '0;
      exp_neg_d  = 1'b0;
      eacc_d     = '0;
      seen_d     = 1'b0;
      lost_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSpace;
      sign_neg_q <= 1'b0;
      mant_q     <= '0;
      scale_q    <= '0;
      sig_q      <= '0;
      exp_neg_q  <= 1'b0;
      eacc_q     <= '0;
      seen_q     <= 1'b0;
      lost_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      sign_neg_q <= sign_neg_d;
      mant_q     <= mant_d;
      scale_q    <= scale_d;
      sig_q      <= sig_d;
      exp_neg_q  <= exp_neg_d;
      eacc_q     <= eacc_d;
      seen_q     <= seen_d;
      lost_q     <= lost_d;
    end
  end

endmodule
